// ===== hw/rtl/mms_pkg.sv =====
// types, constants and brand lookup for the media magic sniffer
// no dependencies; imported by every module of the block
package mms_pkg;

	typedef enum logic [2:0] {
		SIG_UNKNOWN = 3'd0,
		SIG_JPEG    = 3'd1,
		SIG_PNG     = 3'd2,
		SIG_TIFF    = 3'd3,
		SIG_HEIF    = 3'd4,
		SIG_BMFF    = 3'd5
	} sig_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} beat_t;

	localparam logic [4:0] POS_SAT      = 5'd16;
	localparam logic [4:0] POS_JPEG_LEN = 5'd3;
	localparam logic [4:0] POS_TIFF_LEN = 5'd4;
	localparam logic [4:0] POS_BOX_LO   = 5'd4;
	localparam logic [4:0] POS_HDR_LEN  = 5'd8;
	localparam logic [4:0] POS_MINOR_END = 5'd15;
	localparam logic [1:0] PHASE_LAST   = 2'd3;
	localparam int         NUM_BRANDS   = 11;

	localparam logic [7:0] JPEG_MAGIC [3] = '{8'hFF, 8'hD8, 8'hFF};
	localparam logic [7:0] PNG_MAGIC  [8] = '{8'h89, 8'h50, 8'h4E, 8'h47,
	                                          8'h0D, 8'h0A, 8'h1A, 8'h0A};
	localparam logic [7:0] TIFF_LE_MAGIC [4] = '{8'h49, 8'h49, 8'h2A, 8'h00};
	localparam logic [7:0] TIFF_BE_MAGIC [4] = '{8'h4D, 8'h4D, 8'h00, 8'h2A};
	localparam logic [7:0] FTYP_MAGIC    [4] = '{8'h66, 8'h74, 8'h79, 8'h70};

	localparam logic [31:0] IMAGE_BRANDS [NUM_BRANDS] = '{
		32'h61766966, // avif
		32'h61766973, // avis
		32'h68656963, // heic
		32'h68656978, // heix
		32'h6865696D, // heim
		32'h68656973, // heis
		32'h68657663, // hevc
		32'h68656966, // heif
		32'h6D696631, // mif1
		32'h6D736631, // msf1
		32'h6D696166  // miaf
	};

	function automatic logic is_image_brand(input logic [31:0] word);
		logic hit;
		hit = 1'b0;
		for (int i = 0; i < NUM_BRANDS; i++) begin
			if (word == IMAGE_BRANDS[i]) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

endpackage

// ===== hw/rtl/mms_scan.sv =====
// per-header match state and signature decision
// depends on mms_pkg
module mms_scan
	import mms_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  step,
	input  beat_t beat,
	output sig_t  sig_next
);

	logic [4:0]  pos_q, pos_n;
	logic [1:0]  phase_q, phase_n;
	logic [31:0] recent_q, recent_n;
	logic        jpeg_q, jpeg_n;
	logic        png_q, png_n;
	logic [1:0]  tiff_q, tiff_n;
	logic        box_q, box_n;
	logic        brand_q, brand_n;
	logic [7:0]  b;

	assign b = beat.data_byte;

	always_comb begin
		pos_n    = pos_q;
		phase_n  = phase_q;
		recent_n = recent_q;
		jpeg_n   = jpeg_q;
		png_n    = png_q;
		tiff_n   = tiff_q;
		box_n    = box_q;
		brand_n  = brand_q;
		if (beat.has_byte) begin
			if (pos_q < POS_JPEG_LEN && b != JPEG_MAGIC[pos_q[1:0]]) begin
				jpeg_n = 1'b0;
			end
			if (pos_q < POS_HDR_LEN && b != PNG_MAGIC[pos_q[2:0]]) begin
				png_n = 1'b0;
			end
			if (pos_q < POS_TIFF_LEN) begin
				if (b != TIFF_LE_MAGIC[pos_q[1:0]]) begin
					tiff_n[0] = 1'b0;
				end
				if (b != TIFF_BE_MAGIC[pos_q[1:0]]) begin
					tiff_n[1] = 1'b0;
				end
			end
			if (pos_q >= POS_BOX_LO && pos_q < POS_HDR_LEN
				&& b != FTYP_MAGIC[pos_q[1:0]]) begin
				box_n = 1'b0;
			end
			recent_n = {recent_q[23:0], b};
			if (pos_q >= POS_HDR_LEN) begin
				if (phase_q == PHASE_LAST && pos_q != POS_MINOR_END
					&& is_image_brand(recent_n)) begin
					brand_n = 1'b1;
				end
				phase_n = phase_q + 2'd1;
			end
			if (pos_q < POS_SAT) begin
				pos_n = pos_q + 5'd1;
			end
		end
	end

	always_comb begin
		if (pos_n >= POS_JPEG_LEN && jpeg_n) begin
			sig_next = SIG_JPEG;
		end else if (pos_n >= POS_HDR_LEN && png_n) begin
			sig_next = SIG_PNG;
		end else if (pos_n >= POS_TIFF_LEN && tiff_n != 2'b00) begin
			sig_next = SIG_TIFF;
		end else if (pos_n >= POS_HDR_LEN && box_n) begin
			sig_next = brand_n ? SIG_HEIF : SIG_BMFF;
		end else begin
			sig_next = SIG_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			phase_q  <= '0;
			recent_q <= '0;
			jpeg_q   <= 1'b1;
			png_q    <= 1'b1;
			tiff_q   <= 2'b11;
			box_q    <= 1'b1;
			brand_q  <= 1'b0;
		end else if (step) begin
			if (beat.last) begin
				// header done, back to start
				pos_q    <= '0;
				phase_q  <= '0;
				recent_q <= '0;
				jpeg_q   <= 1'b1;
				png_q    <= 1'b1;
				tiff_q   <= 2'b11;
				box_q    <= 1'b1;
				brand_q  <= 1'b0;
			end else begin
				pos_q    <= pos_n;
				phase_q  <= phase_n;
				recent_q <= recent_n;
				jpeg_q   <= jpeg_n;
				png_q    <= png_n;
				tiff_q   <= tiff_n;
				box_q    <= box_n;
				brand_q  <= brand_n;
			end
		end
	end

endmodule

// ===== hw/rtl/mms_obuf.sv =====
// result register holding one signature beat for the output channel
// depends on mms_pkg
module mms_obuf
	import mms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  sig_t       sig_in,
	output logic       can_take,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] signature
);

	logic valid_q;
	sig_t sig_q;

	assign can_take  = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign signature = sig_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (push) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			sig_q <= sig_in;
		end
	end

endmodule

// ===== hw/rtl/media_magic_sniffer_unit.sv =====
// media magic sniffer: file signature detection from streamed header bytes
// depends on mms_pkg, mms_scan, mms_obuf
//
// usage:
//   input channel (in_valid/in_ready) carries one header byte per beat with
//   has_byte and last; has_byte low with last high ends a header with no byte.
//   output channel (out_valid/out_ready) carries one signature beat for each
//   beat marked last, and nothing for other beats.
//   throughput: one input beat per cycle, set by the input register and the
//   match update behind it, while no last beat waits on the result register.
//   an accepted last beat passes the input register, then the result register,
//   which shows its signature on the output channel.
//   when the receiver stalls, the result register holds its signature; bytes
//   that are not last keep flowing, and a further last beat waits in the
//   input register until the result is taken.
//   reset clears the match state to start of header and empties both
//   registers; after each last beat the match state returns to start.
module media_magic_sniffer_unit
	import mms_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] data_byte,
	input  logic       has_byte,
	input  logic       last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [2:0] signature
);

	logic  valid_s1;
	beat_t beat_s1;
	logic  adv;
	logic  can_take;
	sig_t  sig_next;

	assign adv      = valid_s1 && (!beat_s1.last || can_take);
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			beat_s1 <= '{data_byte: data_byte, has_byte: has_byte, last: last};
		end
	end

	mms_scan u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.step     (adv),
		.beat     (beat_s1),
		.sig_next (sig_next)
	);

	mms_obuf u_obuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (adv && beat_s1.last),
		.sig_in    (sig_next),
		.can_take  (can_take),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.signature (signature)
	);

endmodule

// ===== tb/tb_media_magic_sniffer_unit.sv =====
// self-checking testbench for media_magic_sniffer_unit: header bytes in, one signature out
// a directed table with given signatures, then random headers checked against a sniffer model
// depends on mms_pkg and the media_magic_sniffer_unit rtl
`timescale 1ns / 1ps

module tb_media_magic_sniffer_unit;
	import mms_pkg::*;

	typedef enum int {
		PACE_NONE,
		PACE_SEND,
		PACE_RECV,
		PACE_BOTH,
		PACE_HOLD
	} pace_t;

	typedef enum int {
		HDR_JPEG,
		HDR_PNG,
		HDR_TIFF_LE,
		HDR_TIFF_BE,
		HDR_BMFF,
		HDR_NOISE,
		HDR_EMPTY
	} hdr_kind_t;

	typedef struct packed {
		logic [7:0] byte_val;
		logic       has;
		logic       fin;
		logic       typed;
		sig_t       want;
	} dir_row_t;

	localparam int ITEM_TARGET = 1650;
	localparam int SEGMENT     = ITEM_TARGET / 10;
	localparam int HOLD_CYCLES = 300;
	localparam int DRAIN       = 8;
	localparam int CYCLE_LIMIT = 200000;

	localparam pace_t PACE_ORDER [5] = '{PACE_NONE, PACE_SEND, PACE_RECV, PACE_BOTH, PACE_HOLD};

	localparam dir_row_t DIRECTED [24] = '{
		'{8'h00, 1'b0, 1'b1, 1'b1, SIG_UNKNOWN},
		'{8'hFF, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'hD8, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'hFF, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h00, 1'b0, 1'b1, 1'b1, SIG_JPEG},
		'{8'h4D, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'hA5, 1'b0, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h4D, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h00, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h2A, 1'b1, 1'b1, 1'b1, SIG_TIFF},
		'{8'hFF, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'hD8, 1'b1, 1'b1, 1'b1, SIG_UNKNOWN},
		'{8'h00, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h00, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h00, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h18, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h66, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h74, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h79, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h70, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h68, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h65, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h69, 1'b1, 1'b0, 1'b0, SIG_UNKNOWN},
		'{8'h63, 1'b1, 1'b1, 1'b1, SIG_HEIF}
	};

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       has_byte;
	logic       last;
	logic       out_valid;
	logic       out_ready;
	logic [2:0] signature;

	// sniffer model state
	logic [4:0]  hdr_pos;
	logic [1:0]  grp_phase;
	logic [31:0] tail_word;
	logic        jpeg_ok;
	logic        png_ok;
	logic [1:0]  tiff_ok;
	logic        ftyp_ok;
	logic        brand_hit;

	sig_t       expected_sigs [$];
	logic [7:0] hdr_bytes [$];
	pace_t      pace;
	int         items_sent;
	int         fail_count;
	int         hold_left;
	logic       hold_done;
	int         cycle_count;

	media_magic_sniffer_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.data_byte (data_byte),
		.has_byte  (has_byte),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.signature (signature)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic void sniff_clear();
		hdr_pos   = '0;
		grp_phase = '0;
		tail_word = '0;
		jpeg_ok   = 1'b1;
		png_ok    = 1'b1;
		tiff_ok   = 2'b11;
		ftyp_ok   = 1'b1;
		brand_hit = 1'b0;
	endfunction

	function automatic logic sniff_beat(input logic [7:0] b, input logic h, input logic l,
		output sig_t sig);
		sig = SIG_UNKNOWN;
		if (h) begin
			if (hdr_pos < POS_JPEG_LEN && b != JPEG_MAGIC[hdr_pos[1:0]]) begin
				jpeg_ok = 1'b0;
			end
			if (hdr_pos < POS_HDR_LEN && b != PNG_MAGIC[hdr_pos[2:0]]) begin
				png_ok = 1'b0;
			end
			if (hdr_pos < POS_TIFF_LEN) begin
				if (b != TIFF_LE_MAGIC[hdr_pos[1:0]]) begin
					tiff_ok[0] = 1'b0;
				end
				if (b != TIFF_BE_MAGIC[hdr_pos[1:0]]) begin
					tiff_ok[1] = 1'b0;
				end
			end
			if (hdr_pos >= POS_BOX_LO && hdr_pos < POS_HDR_LEN
				&& b != FTYP_MAGIC[hdr_pos[1:0]]) begin
				ftyp_ok = 1'b0;
			end
			tail_word = {tail_word[23:0], b};
			if (hdr_pos >= POS_HDR_LEN) begin
				// minor version group is never a brand
				if (grp_phase == PHASE_LAST && hdr_pos != POS_MINOR_END) begin
					foreach (IMAGE_BRANDS[k]) begin
						if (tail_word == IMAGE_BRANDS[k]) begin
							brand_hit = 1'b1;
						end
					end
				end
				grp_phase = grp_phase + 2'd1;
			end
			if (hdr_pos < POS_SAT) begin
				hdr_pos = hdr_pos + 5'd1;
			end
		end
		if (!l) begin
			return 1'b0;
		end
		if (hdr_pos >= POS_JPEG_LEN && jpeg_ok) begin
			sig = SIG_JPEG;
		end else if (hdr_pos >= POS_HDR_LEN && png_ok) begin
			sig = SIG_PNG;
		end else if (hdr_pos >= POS_TIFF_LEN && tiff_ok != 2'b00) begin
			sig = SIG_TIFF;
		end else if (hdr_pos >= POS_HDR_LEN && ftyp_ok) begin
			sig = brand_hit ? SIG_HEIF : SIG_BMFF;
		end
		sniff_clear();
		return 1'b1;
	endfunction

	function automatic int send_idle_pct(input pace_t p);
		case (p)
			PACE_SEND: return 77;
			PACE_BOTH: return 27;
			default:   return 0;
		endcase
	endfunction

	function automatic int recv_stall_pct(input pace_t p);
		case (p)
			PACE_RECV: return 77;
			PACE_BOTH: return 27;
			default:   return 0;
		endcase
	endfunction

	function automatic logic [31:0] pick_brand();
		logic [31:0] w;
		int          sel;
		sel = $urandom_range(5);
		w   = IMAGE_BRANDS[$urandom_range(NUM_BRANDS - 1)];
		if (sel < 2) begin
			return w;
		end
		if (sel == 2) begin
			// near miss of a known brand
			return w ^ (32'h1 << $urandom_range(31));
		end
		return $urandom;
	endfunction

	function automatic void push_word(input logic [31:0] w);
		hdr_bytes.push_back(w[31:24]);
		hdr_bytes.push_back(w[23:16]);
		hdr_bytes.push_back(w[15:8]);
		hdr_bytes.push_back(w[7:0]);
	endfunction

	task automatic send_beat(input logic [7:0] d, input logic h, input logic l,
		input logic typed, input sig_t want);
		sig_t predicted;
		logic has_result;
		while ($urandom_range(99) < send_idle_pct(pace)) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid  <= 1'b1;
		data_byte <= d;
		has_byte  <= h;
		last      <= l;
		do @(posedge clk); while (!in_ready);
		has_result = sniff_beat(d, h, l, predicted);
		if (has_result) begin
			expected_sigs.push_back(typed ? want : predicted);
		end
		if (h || l) begin
			items_sent++;
		end
	endtask

	task automatic make_header();
		hdr_kind_t   kind;
		int          pick;
		int          n;
		int          idx;
		logic [31:0] w;
		hdr_bytes.delete();
		pick = $urandom_range(99);
		if (pick < 12) kind = HDR_JPEG;
		else if (pick < 24) kind = HDR_PNG;
		else if (pick < 34) kind = HDR_TIFF_LE;
		else if (pick < 44) kind = HDR_TIFF_BE;
		else if (pick < 80) kind = HDR_BMFF;
		else if (pick < 95) kind = HDR_NOISE;
		else kind = HDR_EMPTY;
		case (kind)
			HDR_JPEG: foreach (JPEG_MAGIC[k]) hdr_bytes.push_back(JPEG_MAGIC[k]);
			HDR_PNG: foreach (PNG_MAGIC[k]) hdr_bytes.push_back(PNG_MAGIC[k]);
			HDR_TIFF_LE: foreach (TIFF_LE_MAGIC[k]) hdr_bytes.push_back(TIFF_LE_MAGIC[k]);
			HDR_TIFF_BE: foreach (TIFF_BE_MAGIC[k]) hdr_bytes.push_back(TIFF_BE_MAGIC[k]);
			HDR_BMFF: begin
				push_word($urandom);
				foreach (FTYP_MAGIC[k]) hdr_bytes.push_back(FTYP_MAGIC[k]);
				push_word(pick_brand());
				push_word(pick_brand());
				n = ($urandom_range(15) == 0) ? $urandom_range(8, 14) : $urandom_range(0, 5);
				repeat (n) push_word(pick_brand());
				// partial group at the tail
				w = IMAGE_BRANDS[$urandom_range(NUM_BRANDS - 1)];
				n = $urandom_range(3);
				for (int k = 0; k < n; k++) begin
					hdr_bytes.push_back(w[31 - 8 * k -: 8]);
				end
			end
			default: ;
		endcase
		if (kind != HDR_EMPTY && kind != HDR_BMFF) begin
			n = ($urandom_range(15) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
			repeat (n) hdr_bytes.push_back(8'($urandom));
		end
		if (hdr_bytes.size() > 0 && $urandom_range(7) == 0) begin
			idx = $urandom_range((hdr_bytes.size() < 16 ? hdr_bytes.size() : 16) - 1);
			hdr_bytes[idx] = hdr_bytes[idx] ^ (8'h1 << $urandom_range(7));
		end
		if ($urandom_range(7) == 0) begin
			n = $urandom_range(hdr_bytes.size());
			while (hdr_bytes.size() > n) void'(hdr_bytes.pop_back());
		end
	endtask

	task automatic feed_header();
		logic close_empty;
		close_empty = (hdr_bytes.size() == 0) || ($urandom_range(3) == 0);
		foreach (hdr_bytes[k]) begin
			if ($urandom_range(9) == 0) begin
				send_beat(8'($urandom), 1'b0, 1'b0, 1'b0, SIG_UNKNOWN);
			end
			send_beat(hdr_bytes[k], 1'b1, (k == hdr_bytes.size() - 1) && !close_empty,
				1'b0, SIG_UNKNOWN);
		end
		if (close_empty) begin
			send_beat(8'($urandom), 1'b0, 1'b1, 1'b0, SIG_UNKNOWN);
		end
	endtask

	// result side: check every beat, then pick next ready
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_sigs.size() == 0) begin
					$error("signature: expected none, got %0d", signature);
					fail_count++;
				end else if (signature !== expected_sigs[0]) begin
					$error("signature: expected %0d, got %0d", expected_sigs[0], signature);
					fail_count++;
					void'(expected_sigs.pop_front());
				end else begin
					void'(expected_sigs.pop_front());
				end
			end
			if (pace == PACE_HOLD && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct(pace));
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		arst_n      <= 1'b0;
		in_valid    <= 1'b0;
		data_byte   <= '0;
		has_byte    <= 1'b0;
		last        <= 1'b0;
		out_ready   <= 1'b0;
		pace        = PACE_NONE;
		items_sent  = 0;
		fail_count  = 0;
		hold_left   = 0;
		hold_done   = 1'b0;
		cycle_count = 0;
		sniff_clear();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (DIRECTED[r]) begin
			send_beat(DIRECTED[r].byte_val, DIRECTED[r].has, DIRECTED[r].fin,
				DIRECTED[r].typed, DIRECTED[r].want);
		end
		items_sent = 0;
		while (items_sent < ITEM_TARGET) begin
			pace = PACE_ORDER[(items_sent / SEGMENT) % 5];
			make_header();
			feed_header();
		end
		in_valid <= 1'b0;
		pace = PACE_NONE;
		while (expected_sigs.size() != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (fail_count == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule
